/* src/playfair_cipher_stream_unit_assert.svh */
// Assertion macros shared by the Playfair stream unit RTL.
`ifndef PLAYFAIR_CIPHER_STREAM_UNIT_ASSERT_SVH
`define PLAYFAIR_CIPHER_STREAM_UNIT_ASSERT_SVH

// Checked on every clock edge outside reset.
`define PF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define PF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* src/pfcs_pkg.sv */
// Shared types and constants for the Playfair stream unit.
package pfcs_pkg;

  // Square size and the letter index of X (A..I = 0..8, K..Z = 9..24)
  localparam int unsigned NumCells = 25;
  localparam logic [4:0]  LetterX  = 5'd22;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;    // latch the input transaction
    logic key_place;  // place one key letter
    logic fill_step;  // place one leftover letter in the fill pass
    logic msg_eval;   // evaluate one message byte, build pairs
    logic rd;         // read the square for the current output letter
    logic load;       // load the output register
  } pfcs_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_key;
    logic is_last;
    logic emit_none;
    logic fill_done;
    logic more_letters;
    logic out_free;
  } pfcs_sts_t;

endpackage

/* src/pfcs_ctrl.sv */
// Controller state machine for the Playfair stream unit.
module pfcs_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  pfcs_pkg::pfcs_sts_t  sts_i,
  output pfcs_pkg::pfcs_cmd_t  cmd_o
);
  import pfcs_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StExec = 3'd1;
  localparam logic [2:0] StFill = 3'd2;
  localparam logic [2:0] StRd   = 3'd3;
  localparam logic [2:0] StLoad = 3'd4;

  logic [2:0] state_q, state_d;

  // Next state and commands
  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = StExec;
        end
      end
      StExec: begin
        if (sts_i.is_key) begin
          cmd_o.key_place = 1'b1;
          state_d         = sts_i.is_last ? StFill : StIdle;
        end else begin
          cmd_o.msg_eval = 1'b1;
          state_d        = sts_i.emit_none ? StIdle : StRd;
        end
      end
      StFill: begin
        cmd_o.fill_step = 1'b1;
        if (sts_i.fill_done) state_d = StIdle;
      end
      StRd: begin
        cmd_o.rd = 1'b1;
        state_d  = StLoad;
      end
      StLoad: begin
        if (sts_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = sts_i.more_letters ? StRd : StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != StIdle);

endmodule

/* src/pfcs_dp.sv */
// Datapath for the Playfair stream unit: key square, pairing and output register.
module pfcs_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pfcs_pkg::pfcs_cmd_t  cmd_i,
  output pfcs_pkg::pfcs_sts_t  sts_o,
  input  logic                 cfg_we_i,
  input  logic                 cfg_wdata_i,
  input  logic                 req_type_i,
  input  logic [7:0]           char_byte_i,
  input  logic                 is_last_i,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output logic [6:0]           out_letter_o,
  output logic                 out_last_o
);
  import pfcs_pkg::*;

  // Upper-case a..z, J folds onto I
  function automatic logic [7:0] fold_byte(logic [7:0] b);
    logic [7:0] u;
    u = (b >= 8'h61 && b <= 8'h7A) ? 8'(b - 8'd32) : b;
    return (u == 8'h4A) ? 8'h49 : u;
  endfunction

  // {valid, letter index} of an upper-case letter other than J
  function automatic logic [5:0] letter_idx(logic [7:0] b);
    logic [7:0] d;
    d = 8'(b - 8'h41);
    if (b < 8'h41 || b > 8'h5A || b == 8'h4A) return 6'd0;
    return (b < 8'h4A) ? {1'b1, d[4:0]} : {1'b1, 5'(d - 8'd1)};
  endfunction

  function automatic logic [2:0] row_of(logic [4:0] p);
    if (p < 5'd5)  return 3'd0;
    if (p < 5'd10) return 3'd1;
    if (p < 5'd15) return 3'd2;
    if (p < 5'd20) return 3'd3;
    return 3'd4;
  endfunction

  function automatic logic [4:0] row_base(logic [2:0] r);
    return 5'({r, 2'b00} + {2'b00, r});
  endfunction

  // Step one place along a row or column, wrapping at five
  function automatic logic [2:0] shift5(logic [2:0] v, logic dec);
    if (dec) return (v == 3'd0) ? 3'd4 : 3'(v - 3'd1);
    return (v == 3'd4) ? 3'd0 : 3'(v + 3'd1);
  endfunction

  // Output cell for one letter of a pair (row, column, rectangle rules)
  function automatic logic [4:0] cipher_cell(logic [4:0] p1, logic [4:0] p2,
                                             logic dec, logic second);
    logic [2:0] r1, c1, r2, c2, ra, ca, r, c;
    r1 = row_of(p1);
    r2 = row_of(p2);
    c1 = 3'(p1 - row_base(r1));
    c2 = 3'(p2 - row_base(r2));
    ra = second ? r2 : r1;
    ca = second ? c2 : c1;
    if (r1 == r2) begin
      r = ra;
      c = shift5(ca, dec);
    end else if (c1 == c2) begin
      r = shift5(ra, dec);
      c = ca;
    end else begin
      r = ra;
      c = second ? c1 : c2;
    end
    return 5'(row_base(r) + {2'b00, c});
  endfunction

  function automatic logic [6:0] letter_ascii(logic [4:0] idx);
    return (idx < 5'd9) ? 7'(7'h41 + {2'b00, idx}) : 7'(7'h42 + {2'b00, idx});
  endfunction

  // Captured transaction and mode register
  logic        type_q, last_q, decrypt_q;
  logic [7:0]  byte_q;

  // Key tables and load state
  logic [4:0]  lp_q [NumCells];
  logic [4:0]  sq_mem [NumCells];
  logic [NumCells-1:0] sq_vld_q, used_q;
  logic [4:0]  fill_q, fidx_q;
  logic        loading_q;

  // Pairing state and output letters
  logic [4:0]  pend_q;
  logic        pend_vld_q;
  logic [4:0]  slot_q [4];
  logic [2:0]  nlet_q;
  logic [1:0]  k_q;
  logic [4:0]  rd_mem_q, rd_cell_q;
  logic        rd_vld_q;
  logic        out_valid_q, out_last_q;
  logic [6:0]  out_letter_q;

  // Key placement
  logic [4:0]  fill_e;
  logic [NumCells-1:0] used_e;
  logic [5:0]  key_li;
  logic        can_key, can_fill, wr_en;
  logic [4:0]  wr_addr, wr_letter;

  assign fill_e  = loading_q ? fill_q : 5'd0;
  assign used_e  = loading_q ? used_q : '0;
  assign key_li  = letter_idx(fold_byte(byte_q));
  assign can_key = key_li[5] && (fill_e < 5'(NumCells)) && !used_e[key_li[4:0]];
  assign can_fill = (fill_q < 5'(NumCells)) && !used_q[fidx_q];
  assign wr_en    = (cmd_i.key_place && can_key) || (cmd_i.fill_step && can_fill);
  assign wr_addr  = cmd_i.key_place ? fill_e : fill_q;
  assign wr_letter = cmd_i.key_place ? key_li[4:0] : fidx_q;

  // Message byte evaluation
  logic [5:0]  msg_li;
  logic [4:0]  place, xplace, pp_n, a0, a1;
  logic        pv_n, have_a, have_b;

  always_comb begin
    msg_li = letter_idx(decrypt_q ? byte_q : fold_byte(byte_q));
    place  = msg_li[5] ? lp_q[msg_li[4:0]] : 5'd0;
    xplace = lp_q[LetterX];
    pp_n   = pend_q;
    pv_n   = pend_vld_q;
    have_a = 1'b0;
    a0     = pend_q;
    a1     = place;
    if (!decrypt_q && !msg_li[5]) begin
      // dropped byte
    end else if (!pend_vld_q) begin
      pp_n = place;
      pv_n = 1'b1;
    end else if (!decrypt_q && pend_q == place) begin
      have_a = 1'b1;
      a1     = xplace;
    end else begin
      have_a = 1'b1;
      pv_n   = 1'b0;
    end
    have_b = last_q && pv_n;
  end

  // Current output letter
  logic [4:0]  rd_cell;
  logic [2:0]  k_next;
  logic [4:0]  rd_letter;

  assign rd_cell   = cipher_cell(slot_q[{k_q[1], 1'b0}], slot_q[{k_q[1], 1'b1}],
                                 decrypt_q, k_q[0]);
  assign k_next    = 3'({1'b0, k_q} + 3'd1);
  assign rd_letter = rd_vld_q ? rd_mem_q : rd_cell_q;

  // Transaction capture and mode
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      type_q    <= 1'b0;
      last_q    <= 1'b0;
      byte_q    <= '0;
      decrypt_q <= 1'b0;
    end else begin
      if (cmd_i.capture) begin
        type_q <= req_type_i;
        last_q <= is_last_i;
        byte_q <= char_byte_i;
      end
      if (cfg_we_i) decrypt_q <= cfg_wdata_i;
    end
  end

  // Letter place table, valid bits and key load state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumCells; i++) lp_q[i] <= 5'(i);
      sq_vld_q  <= '0;
      used_q    <= '0;
      fill_q    <= '0;
      fidx_q    <= '0;
      loading_q <= 1'b0;
    end else begin
      if (wr_en) begin
        lp_q[wr_letter]   <= wr_addr;
        sq_vld_q[wr_addr] <= 1'b1;
      end
      if (cmd_i.key_place) begin
        fill_q    <= 5'(fill_e + {4'd0, can_key});
        used_q    <= used_e | (can_key ? (NumCells'(1) << key_li[4:0]) : '0);
        loading_q <= !last_q;
        fidx_q    <= '0;
      end else if (cmd_i.fill_step) begin
        fill_q <= 5'(fill_q + {4'd0, can_fill});
        used_q <= used_q | (can_fill ? (NumCells'(1) << fidx_q) : '0);
        fidx_q <= 5'(fidx_q + 5'd1);
      end
    end
  end

  // Square memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) sq_mem[wr_addr] <= wr_letter;
    if (cmd_i.rd) rd_mem_q <= sq_mem[rd_cell];
  end

  // Default square for cells not yet written, read alongside the memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      rd_cell_q <= rd_cell;
      rd_vld_q  <= sq_vld_q[rd_cell];
    end
  end

  // Pending cell and output pair slots
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q     <= '0;
      pend_vld_q <= 1'b0;
      nlet_q     <= '0;
      k_q        <= '0;
    end else begin
      if (cmd_i.msg_eval) begin
        pend_q     <= pp_n;
        pend_vld_q <= pv_n && !last_q;
        // two letters per pair: 2 for one pair, 4 for two
        nlet_q     <= {have_a && have_b, have_a ^ have_b, 1'b0};
        k_q        <= '0;
      end else if (cmd_i.load) begin
        k_q <= k_next[1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.msg_eval) begin
      slot_q[0] <= have_a ? a0 : pp_n;
      slot_q[1] <= have_a ? a1 : xplace;
      slot_q[2] <= pp_n;
      slot_q[3] <= xplace;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_letter_q <= letter_ascii(rd_letter);
      out_last_q   <= last_q && (k_next == nlet_q);
    end
  end

  // Status
  assign sts_o.is_key       = !type_q;
  assign sts_o.is_last      = last_q;
  assign sts_o.emit_none    = !have_a && !have_b;
  assign sts_o.fill_done    = (fidx_q == 5'(NumCells - 1));
  assign sts_o.more_letters = (k_next != nlet_q);
  assign sts_o.out_free     = !out_valid_q || !out_stall_i;

  assign out_valid_o  = out_valid_q;
  assign out_letter_o = out_letter_q;
  assign out_last_o   = out_last_q;

endmodule

/* src/playfair_cipher_stream_unit.sv */
// Top level of the Playfair stream unit: controller, datapath and checks.
// Key byte: captured, then placed; the last key byte adds a fill pass over the square.
// Message byte: captured and evaluated, then per output letter a square read, then a load,
// the load waiting while the output stalls; up to 4 letters, from at most two pairs.
// The next byte is taken while the final letter still waits in the output register.
// rst_ni (async, low) restores the alphabet square, clears the key and pending state.
`include "playfair_cipher_stream_unit_assert.svh"

module playfair_cipher_stream_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       req_type_i,
  input  logic [7:0] char_byte_i,
  input  logic       is_last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [6:0] out_letter_o,
  output logic       out_last_o
);
  import pfcs_pkg::*;

  pfcs_cmd_t cmd;
  pfcs_sts_t sts;
  logic      in_fire;
  logic      out_room;
  logic      letter_ok;

  pfcs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pfcs_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .req_type_i   (req_type_i),
    .char_byte_i  (char_byte_i),
    .is_last_i    (is_last_i),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .out_letter_o (out_letter_o),
    .out_last_o   (out_last_o)
  );

  // Checks
  assign in_fire   = in_valid_i && !in_stall_o;
  assign out_room  = !out_valid_o || !out_stall_i;
  assign letter_ok = (out_letter_o >= 7'h41) && (out_letter_o <= 7'h5A) &&
                     (out_letter_o != 7'h4A);

  `PF_ASSERT(a_busy_after_accept, in_fire |=> in_stall_o, "accepted byte left input open")
  `PF_ASSERT(a_load_needs_room, cmd.load |-> out_room, "output overwritten while stalled")
  `PF_ASSERT(a_letter_range, out_valid_o |-> letter_ok, "output is not a square letter")
  `PF_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !out_valid_o, "output valid after reset")

endmodule
